@@ rtl/core/abp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB pixel blender package
// Blend mode codes, channel constants, pipeline enable bundle and the
// truncating divide-by-255 used by every colour lane.
// ----------------------------------------------------------------------------
package abp_pkg;

  // Channel geometry of an ARGB8888 pixel
  localparam int unsigned ChW  = 8;
  localparam int unsigned PixW = 4 * ChW;
  localparam int unsigned ShA  = 24;
  localparam int unsigned ShR  = 16;
  localparam int unsigned ShG  = 8;
  localparam logic [ChW-1:0] CH_MAX = 8'hFF;

  // Blend modes; code 3 has no name and blends as normal
  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_ADD      = 2'd1,
    MODE_MULTIPLY = 2'd2
  } blend_mode_e;

  // Per-stage advance strobes shared by the lanes and the merge stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } abp_pipe_en_t;

  // floor(x / 255), exact for x below 65280 (all products stay <= 65025)
  function automatic logic [ChW-1:0] div255(input logic [16:0] x);
    logic [17:0] t;
    t = 18'(x) + 18'd1 + 18'(x[16:8]);
    return t[15:8];
  endfunction

endpackage

@@ rtl/core/abp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB pixel blender channels
// Valid/ready interfaces for the input item (two pixels and a mode) and for
// the result item (one blended pixel).
// ----------------------------------------------------------------------------
interface abp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] background;
  logic [31:0] foreground;
  logic [1:0]  mode;

  modport source (output valid, output background, output foreground, output mode,
                  input ready);
  modport sink   (input valid, input background, input foreground, input mode,
                  output ready);
endinterface

interface abp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] blended;

  modport source (output valid, output blended, input ready);
  modport sink   (input valid, input blended, output ready);
endinterface

@@ rtl/core/abp_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB pixel blender colour lane
// Three-stage mixer for one colour channel: products, first divide and the
// multiply-mode second product, then the final divide.
// ----------------------------------------------------------------------------
module abp_lane import abp_pkg::*; (
  input  logic            clk_i,
  input  abp_pipe_en_t    en_i,
  input  logic [ChW-1:0]  b_i,
  input  logic [ChW-1:0]  f_i,
  input  logic [ChW-1:0]  af_i,
  input  logic [1:0]      mode_i,
  output logic [ChW-1:0]  ch_o
);

  // Stage 1 registers
  logic [15:0]    p1_q, p1_d;
  logic [15:0]    p2_q, p2_d;
  logic [ChW-1:0] b1_q;
  logic [1:0]     mode1_q;

  // Stage 2 registers
  logic [15:0]    m_q, m_d;
  logic           mul2_q;

  // Stage 3 (result) register
  logic [ChW-1:0] ch_q, ch_d;

  logic [ChW-1:0] f_op;
  logic [ChW-1:0] q1;
  logic [8:0]     add_sum;

  // Stage 1: foreground term (255-f for multiply) and background weight
  always_comb begin
    f_op = (mode_i == MODE_MULTIPLY) ? (CH_MAX - f_i) : f_i;
    p1_d = 16'(f_op) * 16'(af_i);
    p2_d = 16'(b_i) * 16'(CH_MAX - af_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      b1_q    <= b_i;
      mode1_q <= mode_i;
    end
  end

  // Stage 2: per-mode result, or the second product for multiply
  always_comb begin
    q1      = div255(17'(p1_q));
    add_sum = 9'(q1) + 9'(b1_q);
    case (mode1_q)
      MODE_ADD:      m_d = 16'(add_sum[8] ? CH_MAX : add_sum[7:0]);
      MODE_MULTIPLY: m_d = 16'(CH_MAX - q1) * 16'(b1_q);
      default:       m_d = 16'(div255(17'(p1_q) + 17'(p2_q)));
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      m_q    <= m_d;
      mul2_q <= (mode1_q == MODE_MULTIPLY);
    end
  end

  // Stage 3: final divide for multiply, pass-through otherwise
  assign ch_d = mul2_q ? div255(17'(m_q)) : m_q[ChW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ch_q <= ch_d;
    end
  end

  assign ch_o = ch_q;

endmodule

@@ rtl/core/abp_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB pixel blender merge stage
// Saturating alpha sum, carried alongside the colour lanes, then packed with
// the three lane results into one ARGB pixel.
// ----------------------------------------------------------------------------
module abp_merge import abp_pkg::*; (
  input  logic             clk_i,
  input  abp_pipe_en_t     en_i,
  input  logic [ChW-1:0]   ab_i,
  input  logic [ChW-1:0]   af_i,
  input  logic [ChW-1:0]   r_i,
  input  logic [ChW-1:0]   g_i,
  input  logic [ChW-1:0]   b_i,
  output logic [PixW-1:0]  blended_o
);

  logic [8:0]     a_sum;
  logic [ChW-1:0] a1_q, a1_d;
  logic [ChW-1:0] a2_q;
  logic [ChW-1:0] a3_q;

  // Alpha: ab + af clamped at 255
  always_comb begin
    a_sum = 9'(ab_i) + 9'(af_i);
    a1_d  = a_sum[8] ? CH_MAX : a_sum[7:0];
  end

  // Keep alpha in step with the lanes
  always_ff @(posedge clk_i) begin
    if (en_i.s1) a1_q <= a1_d;
    if (en_i.s2) a2_q <= a1_q;
    if (en_i.s3) a3_q <= a2_q;
  end

  assign blended_o = {a3_q, r_i, g_i, b_i};

endmodule

@@ rtl/core/argb_pixel_blender.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB pixel blender
// Blends a foreground ARGB8888 pixel over a background pixel in normal, add
// or multiply mode; alpha out is the saturated sum of both alphas.
//
// Usage:
//   in_i  carries background, foreground and mode; an item is taken when
//         valid and ready are both high.
//   out_o carries the blended pixel under the same valid/ready rule.
//   Stages: product, divide/second-product, final divide (the third stage is
//   the output register); out_o.valid rises when the result reaches it.
//   Three colour lanes run side by side in every stage.
//   Throughput is one item per cycle while out_o.ready stays high.
//   When the receiver stalls, the result holds on out_o and empty stages
//   behind it still fill, so up to three items are held before in_i.ready
//   drops. Nothing is lost or repeated.
//   Reset clears the stage valid flags only; no clearing pass is needed and
//   the block accepts items from the first cycle after reset.
// ----------------------------------------------------------------------------
module argb_pixel_blender import abp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  abp_in_if.sink    in_i,
  abp_out_if.source out_o
);

  abp_pipe_en_t   en;
  logic           v1_q, v2_q, v3_q;
  logic [ChW-1:0] r_ch, g_ch, b_ch;

  // Stage advance: a stage moves when it is empty or the next one moves
  always_comb begin
    en.s3 = !v3_q || out_o.ready;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign in_i.ready = en.s1;

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_i.valid;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
    end
  end

  // Colour lanes
  abp_lane u_lane_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .b_i    (in_i.background[ShR +: ChW]),
    .f_i    (in_i.foreground[ShR +: ChW]),
    .af_i   (in_i.foreground[ShA +: ChW]),
    .mode_i (in_i.mode),
    .ch_o   (r_ch)
  );

  abp_lane u_lane_g (
    .clk_i  (clk_i),
    .en_i   (en),
    .b_i    (in_i.background[ShG +: ChW]),
    .f_i    (in_i.foreground[ShG +: ChW]),
    .af_i   (in_i.foreground[ShA +: ChW]),
    .mode_i (in_i.mode),
    .ch_o   (g_ch)
  );

  abp_lane u_lane_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .b_i    (in_i.background[0 +: ChW]),
    .f_i    (in_i.foreground[0 +: ChW]),
    .af_i   (in_i.foreground[ShA +: ChW]),
    .mode_i (in_i.mode),
    .ch_o   (b_ch)
  );

  // Alpha and packing
  abp_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (en),
    .ab_i      (in_i.background[ShA +: ChW]),
    .af_i      (in_i.foreground[ShA +: ChW]),
    .r_i       (r_ch),
    .g_i       (g_ch),
    .b_i       (b_ch),
    .blended_o (out_o.blended)
  );

  assign out_o.valid = v3_q;

endmodule

@@ rtl/core/abp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB pixel blender checker
// Port-level assertions on reset, stall behaviour and pipeline latency.
// ----------------------------------------------------------------------------
module abp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_blended_i
);

  // Once reset has been seen at an edge, no result is shown at the next one
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_blended_i))
    else $error("stalled result changed or dropped");

  // A free-running receiver never back-pressures the input
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output is free");

  // With no output stall, an accepted item shows up as a valid result once it has passed every stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && out_ready_i) ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_i)
    else $error("result missing after three cycles");

endmodule

bind argb_pixel_blender abp_checker u_abp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_blended_i (out_o.blended)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB pixel blender testbench
// Drives background/foreground pixel pairs in every blend mode through the
// blender: a table of directed corner cases first, then random pixels with
// biased alphas. Each blended pixel is checked in order against a typed-in
// result or a local per-channel calculation. Both handshakes idle at
// random, except for one long quiet stretch.
// ----------------------------------------------------------------------------
module tb_top import abp_pkg::*; ();

  localparam int unsigned ClkHalf   = 6;
  localparam int unsigned RstCycles = 8;
  localparam int unsigned NumRandom = 1400;
  localparam int unsigned IdlePct   = 25;
  localparam int unsigned DrainWait = 6;
  // Code 3 carries no enum name and blends as normal
  localparam logic [1:0]  ModeSpare = 2'd3;

  typedef struct packed {
    logic [31:0] bg;
    logic [31:0] fg;
    logic [1:0]  mode;
    logic        known;
    logic [31:0] want;
  } dir_row_t;

  localparam int unsigned NumDir = 21;

  // Directed rows; a known result is typed in, the rest are calculated
  dir_row_t dir_rows [NumDir] = '{
    '{32'h0000_0000, 32'h0000_0000, MODE_NORMAL,   1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_NORMAL,   1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_ADD,      1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_MULTIPLY, 1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, ModeSpare,     1'b1, 32'hFFFF_FFFF},
    '{32'h8011_2233, 32'h00FF_FFFF, MODE_NORMAL,   1'b1, 32'h8011_2233},
    '{32'h8011_2233, 32'h00FF_FFFF, ModeSpare,     1'b1, 32'h8011_2233},
    '{32'h8011_2233, 32'h00FF_FFFF, MODE_ADD,      1'b1, 32'h8011_2233},
    '{32'h8011_2233, 32'hFF00_0000, MODE_MULTIPLY, 1'b1, 32'hFF00_0000},
    '{32'h7F00_0000, 32'h8000_0000, MODE_ADD,      1'b1, 32'hFF00_0000},
    '{32'h00FF_FFFF, 32'hFFFF_FFFF, MODE_ADD,      1'b1, 32'hFFFF_FFFF},
    '{32'h00FF_8040, 32'hFF00_FFFF, MODE_MULTIPLY, 1'b1, 32'hFF00_8040},
    '{32'hFFFF_FFFF, 32'h0000_0000, MODE_MULTIPLY, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'hFFFF_FFFF, MODE_NORMAL,   1'b1, 32'hFFFF_FFFF},
    '{32'h90A0_B0C0, 32'h9010_2030, MODE_NORMAL,   1'b0, 32'h0},
    '{32'h1234_5678, 32'h9ABC_DEF0, MODE_NORMAL,   1'b0, 32'h0},
    '{32'h1234_5678, 32'h9ABC_DEF0, MODE_ADD,      1'b0, 32'h0},
    '{32'h1234_5678, 32'h9ABC_DEF0, MODE_MULTIPLY, 1'b0, 32'h0},
    '{32'hFF00_0000, 32'h01FF_FFFF, MODE_NORMAL,   1'b0, 32'h0},
    '{32'h00FF_FFFF, 32'hFE00_0000, MODE_ADD,      1'b0, 32'h0},
    '{32'h0080_C0FF, 32'h8040_6080, MODE_MULTIPLY, 1'b0, 32'h0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;
  int   mismatch_cnt = 0;
  logic [31:0] pending_px_q [$];

  abp_in_if  blend_in ();
  abp_out_if blend_out ();

  argb_pixel_blender u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (blend_in),
    .out_o  (blend_out)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Expected blended pixel, channel by channel, divisions truncating
  function automatic logic [31:0] blend_pixel(input logic [31:0] bg, input logic [31:0] fg,
                                              input logic [1:0] mode);
    int unsigned full, af, a, b, f, v, dark, lane, sh;
    logic [31:0] px;
    full = CH_MAX;
    af   = fg[ShA +: ChW];
    a    = bg[ShA +: ChW] + af;
    if (a > full) a = full;
    px = '0;
    px[ShA +: ChW] = a[ChW-1:0];
    for (lane = 0; lane < 3; lane++) begin
      sh = lane * ChW;
      b  = bg[sh +: ChW];
      f  = fg[sh +: ChW];
      case (blend_mode_e'(mode))
        MODE_ADD: begin
          v = (f * af) / full + b;
          if (v > full) v = full;
        end
        MODE_MULTIPLY: begin
          dark = ((full - f) * af) / full;
          v    = ((full - dark) * b) / full;
        end
        default: begin
          v = (f * af + b * (full - af)) / full;
        end
      endcase
      px[sh +: ChW] = v[ChW-1:0];
    end
    return px;
  endfunction

  // Offer one item, with a random gap ahead of it; queue its result on take-up
  task automatic offer_pixels(input logic [31:0] bg, input logic [31:0] fg,
                              input logic [1:0] mode, input logic known,
                              input logic [31:0] want);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      blend_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    blend_in.valid      <= 1'b1;
    blend_in.background <= bg;
    blend_in.foreground <= fg;
    blend_in.mode       <= mode;
    do @(posedge clk_i); while (!blend_in.ready);
    pending_px_q.push_back(known ? want : blend_pixel(bg, fg, mode));
    @(negedge clk_i);
  endtask

  // Alpha biased towards the extremes now and then
  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    px = $urandom;
    if ($urandom_range(0, 3) == 0) px[ShA +: ChW] = $urandom_range(0, 1) ? CH_MAX : 8'h00;
    return px;
  endfunction

  // Receiver: random stalls, none while calm
  always @(negedge clk_i) begin
    blend_out.ready <= rst_ni && (calm || $urandom_range(0, 99) >= IdlePct);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && blend_out.valid && blend_out.ready) begin
      if (pending_px_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: blended expected none actual %08h", $time, blend_out.blended);
      end else begin
        if (blend_out.blended !== pending_px_q[0]) begin
          mismatch_cnt++;
          $display("%0t: blended expected %08h actual %08h", $time, pending_px_q[0],
                   blend_out.blended);
        end
        void'(pending_px_q.pop_front());
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned idx;
    blend_in.valid      = 1'b0;
    blend_in.background = '0;
    blend_in.foreground = '0;
    blend_in.mode       = MODE_NORMAL;
    blend_out.ready     = 1'b0;
    repeat (RstCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (idx = 0; idx < NumDir; idx++) begin
      offer_pixels(dir_rows[idx].bg, dir_rows[idx].fg, dir_rows[idx].mode,
                   dir_rows[idx].known, dir_rows[idx].want);
    end

    for (idx = 0; idx < NumRandom; idx++) begin
      calm = (idx >= 500 && idx < 800);
      offer_pixels(rand_pixel(), rand_pixel(), 2'($urandom_range(0, 3)), 1'b0, 32'h0);
    end
    calm = 1'b0;
    blend_in.valid <= 1'b0;

    while (pending_px_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_px_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
